// File: src/eau_pkg.sv
// ----------------------------------------------------------------------------
// eau_pkg: shared types and helpers for the 6502 effective address unit
// Holds the input word and result word layouts, the mode and phase codes,
// and small constructors for result words.
// ----------------------------------------------------------------------------
package eau_pkg;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DATA  = 1'b1;

	localparam logic [7:0]  PAGE_ZERO  = 8'h00;
	localparam logic [15:0] ADDR_NONE  = 16'h0000;

	typedef enum logic [3:0] {
		MODE_IMP  = 4'd0,
		MODE_ACC  = 4'd1,
		MODE_IMM  = 4'd2,
		MODE_ZP   = 4'd3,
		MODE_ZPX  = 4'd4,
		MODE_ZPY  = 4'd5,
		MODE_REL  = 4'd6,
		MODE_ABS  = 4'd7,
		MODE_ABSX = 4'd8,
		MODE_ABSY = 4'd9,
		MODE_IND  = 4'd10,
		MODE_INDX = 4'd11,
		MODE_INDY = 4'd12
	} mode_t;

	// Operand or pointer byte awaited next, counting from one; idle when none pending.
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_1    = 3'd1,
		PH_2    = 3'd2,
		PH_3    = 3'd3,
		PH_4    = 3'd4
	} phase_t;

	typedef struct packed {
		logic        action;
		logic [3:0]  mode;
		logic [15:0] prog_counter;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [7:0]  read_data;
	} item_t;

	typedef struct packed {
		logic        done_res;
		logic [15:0] read_address;
		logic [15:0] effective_address;
		logic [15:0] next_pc;
		logic        page_penalty;
	} result_t;

	function automatic result_t mk_req(input logic [15:0] addr);
		result_t r;
		r.done_res          = 1'b0;
		r.read_address      = addr;
		r.effective_address = ADDR_NONE;
		r.next_pc           = ADDR_NONE;
		r.page_penalty      = 1'b0;
		return r;
	endfunction

	function automatic result_t mk_done(input logic [15:0] ea, input logic [15:0] npc,
			input logic pen);
		result_t r;
		r.done_res          = 1'b1;
		r.read_address      = ADDR_NONE;
		r.effective_address = ea;
		r.next_pc           = npc;
		r.page_penalty      = pen;
		return r;
	endfunction

endpackage

// File: src/eau_in_reg.sv
// ----------------------------------------------------------------------------
// eau_in_reg: input word register
// Captures one input word and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module eau_in_reg
	import eau_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item_in,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	logic valid_q;

	// A new word can enter when the register is empty or the held one leaves in the same cycle.
	assign in_ready = !valid_q || take;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

endmodule

// File: src/eau_core.sv
// ----------------------------------------------------------------------------
// eau_core: addressing mode sequencer
// Holds the resolution state and turns each input word into at most one
// result word: a byte read request or the resolved address.
// ----------------------------------------------------------------------------
module eau_core
	import eau_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    fire,
	output logic    emit,
	output result_t res
);

	typedef struct packed {
		phase_t      phase;
		mode_t       mode;
		logic [15:0] pc;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [15:0] pointer;
		logic [7:0]  low;
	} st_t;

	st_t         cur_q;
	st_t         nxt;
	logic [15:0] pc_inc;
	logic [15:0] word;
	logic [15:0] sum_x;
	logic [15:0] sum_y;
	logic [7:0]  zp_x;
	logic [7:0]  zp_y;
	logic [7:0]  ptr_inc;
	logic        pen_x;
	logic        pen_y;

	assign pc_inc  = cur_q.pc + 16'd1;
	assign word    = {item.read_data, cur_q.low};
	assign sum_x   = word + {PAGE_ZERO, cur_q.x};
	assign sum_y   = word + {PAGE_ZERO, cur_q.y};
	assign pen_x   = (sum_x[15:8] != word[15:8]);
	assign pen_y   = (sum_y[15:8] != word[15:8]);
	assign zp_x    = item.read_data + cur_q.x;
	assign zp_y    = item.read_data + cur_q.y;
	// Pointer high byte never takes the carry: zero page wrap and the JMP bug.
	assign ptr_inc = cur_q.pointer[7:0] + 8'd1;

	always_comb begin
		nxt  = cur_q;
		emit = 1'b0;
		res  = mk_req(ADDR_NONE);
		if (item.action == ACT_START) begin
			emit       = 1'b1;
			nxt.mode   = mode_t'(item.mode);
			nxt.pc     = item.prog_counter;
			nxt.x      = item.index_x;
			nxt.y      = item.index_y;
			nxt.phase  = PH_IDLE;
			if (item.mode == MODE_IMM) begin
				res = mk_done(item.prog_counter, item.prog_counter + 16'd1, 1'b0);
			end else if (item.mode inside {[MODE_ZP:MODE_INDY]}) begin
				nxt.phase = PH_1;
				res       = mk_req(item.prog_counter);
			end else begin
				res = mk_done(ADDR_NONE, item.prog_counter, 1'b0);
			end
		end else if (cur_q.phase != PH_IDLE) begin
			emit      = 1'b1;
			nxt.phase = PH_IDLE;
			case (cur_q.phase)
				PH_1: begin
					nxt.pc = pc_inc;
					case (cur_q.mode)
						MODE_ZP:  res = mk_done({PAGE_ZERO, item.read_data}, pc_inc, 1'b0);
						MODE_ZPX: res = mk_done({PAGE_ZERO, zp_x}, pc_inc, 1'b0);
						MODE_ZPY: res = mk_done({PAGE_ZERO, zp_y}, pc_inc, 1'b0);
						MODE_REL: begin
							res = mk_done({{8{item.read_data[7]}}, item.read_data},
								pc_inc, 1'b0);
						end
						MODE_INDX: begin
							nxt.pointer = {PAGE_ZERO, zp_x};
							nxt.phase   = PH_2;
							res         = mk_req({PAGE_ZERO, zp_x});
						end
						MODE_INDY: begin
							nxt.pointer = {PAGE_ZERO, item.read_data};
							nxt.phase   = PH_2;
							res         = mk_req({PAGE_ZERO, item.read_data});
						end
						default: begin
							nxt.low   = item.read_data;
							nxt.phase = PH_2;
							res       = mk_req(pc_inc);
						end
					endcase
				end
				PH_2: begin
					case (cur_q.mode)
						MODE_ABS: begin
							nxt.pc = pc_inc;
							res    = mk_done(word, pc_inc, 1'b0);
						end
						MODE_ABSX: begin
							nxt.pc = pc_inc;
							res    = mk_done(sum_x, pc_inc, pen_x);
						end
						MODE_ABSY: begin
							nxt.pc = pc_inc;
							res    = mk_done(sum_y, pc_inc, pen_y);
						end
						MODE_IND: begin
							nxt.pc      = pc_inc;
							nxt.pointer = word;
							nxt.phase   = PH_3;
							res         = mk_req(word);
						end
						MODE_INDX, MODE_INDY: begin
							nxt.low   = item.read_data;
							nxt.phase = PH_3;
							res       = mk_req({PAGE_ZERO, ptr_inc});
						end
						default: res = mk_done(ADDR_NONE, cur_q.pc, 1'b0);
					endcase
				end
				PH_3: begin
					case (cur_q.mode)
						MODE_IND: begin
							nxt.low   = item.read_data;
							nxt.phase = PH_4;
							res       = mk_req({cur_q.pointer[15:8], ptr_inc});
						end
						MODE_INDX: res = mk_done(word, cur_q.pc, 1'b0);
						MODE_INDY: res = mk_done(sum_y, cur_q.pc, pen_y);
						default:   res = mk_done(ADDR_NONE, cur_q.pc, 1'b0);
					endcase
				end
				PH_4: begin
					if (cur_q.mode == MODE_IND) begin
						res = mk_done(word, cur_q.pc, 1'b0);
					end else begin
						res = mk_done(ADDR_NONE, cur_q.pc, 1'b0);
					end
				end
				default: res = mk_done(ADDR_NONE, cur_q.pc, 1'b0);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (fire) begin
			cur_q <= nxt;
		end
	end

	// A resolved address ends the sequence; a request keeps it open.
	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit && res.done_res |=> cur_q.phase == PH_IDLE)
		else $error("phase not idle after a resolved address");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit && !res.done_res |=> cur_q.phase != PH_IDLE)
		else $error("phase idle after a read request");

	a_pen_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.page_penalty |-> res.done_res)
		else $error("page penalty on a read request");

	a_idle_data: assert property (@(posedge clk) disable iff (!arst_n)
		item.action == ACT_DATA && cur_q.phase == PH_IDLE |-> !emit)
		else $error("result for a data word while idle");

endmodule

// File: src/eau_out_reg.sv
// ----------------------------------------------------------------------------
// eau_out_reg: result word register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module eau_out_reg
	import eau_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_s2
);

	logic valid_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && space) begin
			res_s2 <= res_in;
		end
	end

endmodule

// File: src/cpu6502_effective_address_unit.sv
// ----------------------------------------------------------------------------
// cpu6502_effective_address_unit: 6502 addressing mode resolver
// Resolves the effective address for all thirteen 6502 addressing modes
// through a stream of start words and read data words.
// ----------------------------------------------------------------------------
// A start word (action 0) brings the mode, PC, X and Y. Immediate, implied,
// accumulator and undefined modes finish at once; every other mode answers
// with a read request (done_res 0, read_address set), and each following
// data word (action 1, read_data) carrying that byte produces the next
// request or the final result (done_res 1, effective_address, next_pc,
// page_penalty). Zero page indexing and indirect pointers wrap within their
// page, JMP indirect keeps the original page-wrap quirk, and relative mode
// returns the sign-extended offset. A data word with no resolution open is
// taken and dropped; a start word while one is open abandons it. The unit
// takes one word per clock while the consumer keeps up: each word passes
// through an input register and one pass of short adders and compares into
// a result register, which holds its result on the outputs until the
// consumer takes it. While a result waits for the consumer, the input
// register takes one more word; then the input stalls until the result is
// taken, except that a data word with no resolution open still passes and
// is dropped.
module cpu6502_effective_address_unit
	import eau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [3:0]  mode,
	input  logic [15:0] prog_counter,
	input  logic [7:0]  index_x,
	input  logic [7:0]  index_y,
	input  logic [7:0]  read_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        done_res,
	output logic [15:0] read_address,
	output logic [15:0] effective_address,
	output logic [15:0] next_pc,
	output logic        page_penalty
);

	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    take;
	logic    emit;
	logic    space;
	result_t res;
	result_t res_s2;

	assign item_in.action       = action;
	assign item_in.mode         = mode;
	assign item_in.prog_counter = prog_counter;
	assign item_in.index_x      = index_x;
	assign item_in.index_y      = index_y;
	assign item_in.read_data    = read_data;

	// The held word moves on when it makes no result, or when the result
	// register has room for the one it makes.
	assign take = valid_s1 && (!emit || space);

	eau_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_in  (item_in),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	eau_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (take),
		.emit   (emit),
		.res    (res)
	);

	eau_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && emit),
		.res_in    (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign done_res          = res_s2.done_res;
	assign read_address      = res_s2.read_address;
	assign effective_address = res_s2.effective_address;
	assign next_pc           = res_s2.next_pc;
	assign page_penalty      = res_s2.page_penalty;

endmodule
